@@ rtl/core/irlc_pkg.sv @@
package irlc_pkg;

	localparam int CODE_BITS = 64;
	localparam int KEYS = 16;
	localparam int KEY_W = 4;
	localparam int LEN_W = 7;

	localparam logic [1:0] KIND_PAIR = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_TABLE = 2'd3;

	localparam logic [2:0] EV_SHORT = 3'd0;
	localparam logic [2:0] EV_LONG = 3'd1;
	localparam logic [2:0] EV_REPEAT = 3'd2;
	localparam logic [2:0] EV_RELEASE = 3'd3;
	localparam logic [2:0] EV_NEW = 3'd4;
	localparam logic [2:0] EV_NEW_AGAIN = 3'd5;

	localparam logic [1:0] REG_RELEASE = 2'd0;
	localparam logic [1:0] REG_LONG = 2'd1;
	localparam logic [1:0] REG_REPEAT = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] space_width;
		logic [15:0] mark_width;
		logic [3:0] table_key;
		logic [6:0] table_length;
		logic [63:0] table_space_bits;
		logic [63:0] table_mark_bits;
	} req_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [3:0] key_index;
	} res_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [CODE_BITS-1:0] space_bits;
		logic [CODE_BITS-1:0] mark_bits;
	} code_t;

	localparam logic [2:0] OP_MATCH = 3'd0;
	localparam logic [2:0] OP_TICK = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_REPEAT = 3'd3;

	typedef struct packed {
		logic [2:0] op;
		logic [KEY_W-1:0] key;
		code_t code;
	} cmd_t;

	function automatic logic [CODE_BITS-1:0] refill_mask();
		logic [CODE_BITS-1:0] m;
		m = '0;
		for (int i = 0; i < (CODE_BITS / 8) * 8; i++) m[i] = 1'b1;
		return m;
	endfunction

	function automatic logic [1:0] classify(input logic [15:0] r, input logic [15:0] w);
		logic [16:0] q;
		q = {3'b0, r[15:2]};
		if (w < r) begin
			if ({1'b0, w} < ({1'b0, r} - q)) return 2'd2;
		end else if ({1'b0, w} > ({1'b0, r} + q)) begin
			return 2'd1;
		end
		return 2'd0;
	endfunction

endpackage

@@ rtl/core/ir_learned_code_receiver_core.sv @@
// Channel   Ports                         Direction
// request   start, busy, req              in
// result    done, res                     out
// config    cfg_we, cfg_index, cfg_data   in
// The front part takes each request; tick, table and captured frame-end requests are queued.
// Frame-end matches may scan the table (SCAN, DECIDE); the queue waits meanwhile.
// busy is high while three or more requests sit in the four-entry queue.
// Reset clears all control state; the key table holds garbage until written.
// The result side cannot stall; done pulses for one cycle.
module ir_learned_code_receiver_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input irlc_pkg::req_t req,
	output logic done,
	output irlc_pkg::res_t res,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);
	import irlc_pkg::*;

	logic f_valid, q_ne, q_full, q_pop;
	cmd_t f_cmd, q_cmd;
	logic [7:0] rel_q, long_q, rep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q <= 8'd8;
			long_q <= 8'd60;
			rep_q <= 8'd12;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RELEASE: rel_q <= cfg_data;
				REG_LONG: long_q <= cfg_data;
				REG_REPEAT: rep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = q_full;

	irlc_front u_front (.clk, .arst_n, .in_valid(start && !busy), .req,
		.cmd_valid(f_valid), .cmd(f_cmd));

	irlc_fifo u_fifo (.clk, .arst_n, .push(f_valid), .wdata(f_cmd), .pop(q_pop),
		.not_empty(q_ne), .full(q_full), .rdata(q_cmd));

	irlc_back u_back (.clk, .arst_n, .cmd_valid(q_ne), .cmd(q_cmd), .cmd_pop(q_pop),
		.release_ticks(rel_q), .long_press_ticks(long_q),
		.repeat_interval_ticks(rep_q), .done, .res);
endmodule

@@ rtl/core/irlc_front.sv @@
module irlc_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input irlc_pkg::req_t req,
	output logic cmd_valid,
	output irlc_pkg::cmd_t cmd
);
	import irlc_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_READY = 3'd1;
	localparam logic [2:0] PH_SMARK = 3'd2;
	localparam logic [2:0] PH_SSPACE = 3'd3;
	localparam logic [2:0] PH_COLLECT = 3'd4;

	logic [2:0] phase_q;
	logic [15:0] ref_mark_q, ref_space_q;
	code_t cap_q;

	logic [15:0] rs;
	logic [1:0] cs, cm;
	logic [5:0] pos;
	logic [CODE_BITS-1:0] sm, mm;

	always_comb begin
		rs = (phase_q == PH_SSPACE) ? req.space_width : ref_space_q;
		cs = classify(rs, req.space_width);
		cm = classify(ref_mark_q, req.mark_width);
		pos = cap_q.len[5:0];
		sm = (cs == 2'd2) ? refill_mask() : cap_q.space_bits;
		mm = (cm == 2'd2) ? refill_mask() : cap_q.mark_bits;
		sm[pos] = (cs == 2'd1);
		mm[pos] = (cm == 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ref_mark_q <= '0;
			ref_space_q <= '0;
			cap_q <= '0;
			cmd_valid <= 1'b0;
		end else begin
			cmd_valid <= 1'b0;
			if (in_valid) begin
				case (req.kind)
					KIND_PAIR: begin
						case (phase_q)
							PH_READY: phase_q <= PH_SMARK;
							PH_SMARK: begin
								ref_mark_q <= req.mark_width;
								phase_q <= PH_SSPACE;
							end
							PH_SSPACE, PH_COLLECT: begin
								phase_q <= PH_COLLECT;
								ref_space_q <= rs;
								if (cap_q.len < LEN_W'(CODE_BITS)) begin
									if (cs == 2'd2) ref_space_q <= req.space_width;
									if (cm == 2'd2) ref_mark_q <= req.mark_width;
									cap_q.space_bits <= sm;
									cap_q.mark_bits <= mm;
									cap_q.len <= cap_q.len + 1'b1;
								end
							end
							default: ;
						endcase
					end
					KIND_FRAME: begin
						phase_q <= PH_READY;
						if (phase_q >= PH_SSPACE) begin
							cmd_valid <= 1'b1;
							cmd.op <= OP_MATCH;
							cmd.code <= cap_q;
							cap_q <= '0;
						end
					end
					KIND_TICK: begin
						cmd_valid <= 1'b1;
						cmd.op <= OP_TICK;
					end
					default: begin
						cmd_valid <= 1'b1;
						cmd.op <= OP_WRITE;
						cmd.key <= req.table_key;
						cmd.code <= '{len: req.table_length,
							space_bits: req.table_space_bits,
							mark_bits: req.table_mark_bits};
					end
				endcase
			end
		end
	end
endmodule

@@ rtl/core/irlc_fifo.sv @@
module irlc_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input irlc_pkg::cmd_t wdata,
	input logic pop,
	output logic not_empty,
	output logic full,
	output irlc_pkg::cmd_t rdata
);
	import irlc_pkg::*;

	cmd_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	// One slot stays free for the request still held in the front part.
	assign not_empty = (cnt_q != 3'd0);
	assign full = (cnt_q >= 3'd3);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

@@ rtl/core/irlc_back.sv @@
module irlc_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input irlc_pkg::cmd_t cmd,
	output logic cmd_pop,
	input logic [7:0] release_ticks,
	input logic [7:0] long_press_ticks,
	input logic [7:0] repeat_interval_ticks,
	output logic done,
	output irlc_pkg::res_t res
);
	import irlc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	code_t table_q [KEYS];
	code_t rd_q;
	logic [1:0] st_q;
	logic [KEY_W:0] idx_q;
	logic [KEY_W:0] found_q;
	code_t code_q;
	code_t unknown_q;
	logic [KEY_W:0] last_key_q;
	logic [7:0] hold_cd_q, hold_ticks_q, ht_inc;
	logic idle_now;

	assign idle_now = (st_q == ST_IDLE);
	assign cmd_pop = idle_now && cmd_valid;
	assign ht_inc = (hold_ticks_q != 8'hff) ? hold_ticks_q + 8'd1 : hold_ticks_q;

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_WRITE) table_q[cmd.key] <= cmd.code;
		rd_q <= table_q[idx_q[KEY_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			found_q <= '0;
			unknown_q <= '0;
			last_key_q <= '1;
			hold_cd_q <= '0;
			hold_ticks_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.op)
							OP_MATCH: begin
								if (hold_cd_q != 8'd0) begin
									hold_cd_q <= release_ticks;
								end else begin
									hold_cd_q <= release_ticks;
									code_q <= cmd.code;
									idx_q <= '0;
									found_q <= (KEY_W+1)'(KEYS);
									st_q <= ST_SCAN;
								end
							end
							OP_TICK: begin
								if (hold_cd_q != 8'd0) begin
									hold_cd_q <= hold_cd_q - 8'd1;
									if (last_key_q < (KEY_W+1)'(KEYS)) begin
										if (hold_cd_q == 8'd1) begin
											last_key_q <= '1;
											done <= 1'b1;
											if (hold_ticks_q < long_press_ticks) begin
												res <= '{EV_SHORT, last_key_q[KEY_W-1:0]};
											end else begin
												res <= '{EV_RELEASE, '0};
											end
										end else begin
											hold_ticks_q <= ht_inc;
											if (ht_inc == long_press_ticks) begin
												done <= 1'b1;
												res <= '{EV_LONG, last_key_q[KEY_W-1:0]};
											end else if ({1'b0, ht_inc} == {1'b0, long_press_ticks}
												+ {1'b0, repeat_interval_ticks}) begin
												hold_ticks_q <= long_press_ticks;
												done <= 1'b1;
												res <= '{EV_REPEAT, last_key_q[KEY_W-1:0]};
											end
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (idx_q != '0 && rd_q == code_q && found_q == (KEY_W+1)'(KEYS))
						found_q <= idx_q - 1'b1;
					if (idx_q == (KEY_W+1)'(KEYS)) st_q <= ST_DECIDE;
					else idx_q <= idx_q + 1'b1;
				end
				default: begin
					st_q <= ST_IDLE;
					idx_q <= '0;
					if (found_q != last_key_q) begin
						last_key_q <= found_q;
						hold_ticks_q <= '0;
						if (found_q == (KEY_W+1)'(KEYS)) begin
							done <= 1'b1;
							res <= '{EV_NEW, '0};
							unknown_q <= code_q;
						end
					end else if (found_q == (KEY_W+1)'(KEYS)) begin
						if (unknown_q == code_q) begin
							done <= 1'b1;
							res <= '{EV_NEW_AGAIN, '0};
						end else begin
							last_key_q <= '1;
						end
					end
				end
			endcase
		end
	end
endmodule
